FILE: rtl/generational_handle_allocator_macros.svh
// assertion helpers for the handle allocator
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF

`define GHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define GHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define GHA_ASSERT(lbl, prop, msg)

`define GHA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/gha_pkg.sv
package gha_pkg;

  localparam int IDX_W         = 10;
  localparam int GEN_W         = 32;
  localparam int MODE_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int NUM_SLOTS_DEF = 1024;

  typedef enum logic [MODE_W-1:0] {
    MODE_SPAWN = 2'd0,
    MODE_KILL  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic             live;
    logic [GEN_W-1:0] gen;
  } slot_t;

endpackage

FILE: rtl/generational_handle_allocator.sv
// pipeline: an accepted beat is held in s1, then its result in the output register
// throughput: one beat per cycle while out_stall is low; slot and free-stack memories
// have one write and one registered read per cycle, with forwarding from the beat ahead
// reset: free count and fresh-index counter clear at once; memories are not cleared and
// need no clearing pass, so the block takes beats from the first cycle after reset
`include "generational_handle_allocator_macros.svh"

module generational_handle_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gha_pkg::MODE_W-1:0]    in_mode,
  input  logic [gha_pkg::IDX_W-1:0]     in_handle_index,
  input  logic [gha_pkg::GEN_W-1:0]     in_handle_generation,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gha_pkg::IDX_W-1:0]     out_index,
  output logic [gha_pkg::GEN_W-1:0]     out_generation,
  output logic                          out_is_alive,
  output logic [gha_pkg::STATUS_W-1:0]  out_status
);
  import gha_pkg::*;

  // slot count comes from the package default, which matches the handle index width
  localparam int NUM_SLOTS = NUM_SLOTS_DEF;
  localparam int AW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef struct packed {
    logic [AW-1:0]    idx;
    logic [GEN_W-1:0] gen;
  } stk_t;

  slot_t slot_mem_r [NUM_SLOTS];
  stk_t  stk_mem_r  [NUM_SLOTS];

  logic              s1_valid_r;
  logic [MODE_W-1:0] s1_mode_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [GEN_W-1:0]  s1_gen_r;
  slot_t             slot_q_r, slot_fwd_data_r, slot_cur;
  stk_t              stk_q_r, stk_fwd_data_r, stk_cur;
  logic              slot_fwd_r, stk_fwd_r;
  logic [CW-1:0]     free_count_r, free_count_nxt;
  logic [CW-1:0]     next_fresh_r, next_fresh_nxt;

  logic                out_valid_r;
  logic [IDX_W-1:0]    out_index_r;
  logic [GEN_W-1:0]    out_generation_r;
  logic                out_is_alive_r;
  logic [STATUS_W-1:0] out_status_r;

  logic                in_acc, s1_adv, hit;
  logic [IDX_W-1:0]    res_idx;
  logic [GEN_W-1:0]    res_gen;
  logic                res_alive;
  status_t             res_status;
  logic                slot_we, stk_we;
  logic [AW-1:0]       slot_waddr, slot_raddr, stk_waddr, stk_raddr;
  slot_t               slot_wdata;
  stk_t                stk_wdata;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign slot_cur = slot_fwd_r ? slot_fwd_data_r : slot_q_r;
  assign stk_cur  = stk_fwd_r ? stk_fwd_data_r : stk_q_r;

  // next_fresh never exceeds the slot count, so this also bounds the index
  assign hit = (32'(s1_idx_r) < 32'(next_fresh_r)) && slot_cur.live &&
               (slot_cur.gen == s1_gen_r);

  always_comb begin
    res_idx        = s1_idx_r;
    res_gen        = s1_gen_r;
    res_alive      = 1'b0;
    res_status     = ST_DONE;
    slot_we        = 1'b0;
    slot_waddr     = AW'(s1_idx_r);
    slot_wdata     = '{live: 1'b0, gen: s1_gen_r + 1'b1};
    stk_we         = 1'b0;
    stk_waddr      = AW'(free_count_r);
    stk_wdata      = '{idx: AW'(s1_idx_r), gen: s1_gen_r + 1'b1};
    free_count_nxt = free_count_r;
    next_fresh_nxt = next_fresh_r;
    case (s1_mode_r)
      MODE_SPAWN: begin
        if (free_count_r != '0) begin
          free_count_nxt = free_count_r - 1'b1;
          res_idx        = IDX_W'(stk_cur.idx);
          res_gen        = stk_cur.gen;
          slot_we        = 1'b1;
          slot_waddr     = stk_cur.idx;
          slot_wdata     = '{live: 1'b1, gen: stk_cur.gen};
        end else if (next_fresh_r != CW'(NUM_SLOTS)) begin
          res_idx        = IDX_W'(next_fresh_r);
          res_gen        = '0;
          slot_we        = 1'b1;
          slot_waddr     = AW'(next_fresh_r);
          slot_wdata     = '{live: 1'b1, gen: '0};
          next_fresh_nxt = next_fresh_r + 1'b1;
        end else begin
          res_idx    = '0;
          res_gen    = '0;
          res_status = ST_FULL;
        end
      end
      MODE_KILL: begin
        if (hit) begin
          res_alive = 1'b1;
          slot_we   = 1'b1;
          if (free_count_r != CW'(NUM_SLOTS)) begin
            stk_we         = 1'b1;
            free_count_nxt = free_count_r + 1'b1;
          end
        end else begin
          res_status = ST_IGNORED;
        end
      end
      default: begin
        res_alive = hit;
      end
    endcase
    if (!s1_adv) begin
      slot_we        = 1'b0;
      stk_we         = 1'b0;
      free_count_nxt = free_count_r;
      next_fresh_nxt = next_fresh_r;
    end
  end

  // reads for the incoming beat see the state left by the beat ahead
  assign slot_raddr = AW'(in_handle_index);
  assign stk_raddr  = AW'(free_count_nxt - 1'b1);

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem_r[slot_waddr] <= slot_wdata;
    end
    if (stk_we) begin
      stk_mem_r[stk_waddr] <= stk_wdata;
    end
    if (in_acc) begin
      slot_q_r        <= slot_mem_r[slot_raddr];
      stk_q_r         <= stk_mem_r[stk_raddr];
      slot_fwd_r      <= slot_we && (slot_waddr == slot_raddr);
      slot_fwd_data_r <= slot_wdata;
      stk_fwd_r       <= stk_we && (stk_waddr == stk_raddr);
      stk_fwd_data_r  <= stk_wdata;
      s1_mode_r       <= in_mode;
      s1_idx_r        <= in_handle_index;
      s1_gen_r        <= in_handle_generation;
    end
    if (s1_adv) begin
      out_index_r      <= res_idx;
      out_generation_r <= res_gen;
      out_is_alive_r   <= res_alive;
      out_status_r     <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      free_count_r <= '0;
      next_fresh_r <= '0;
    end else begin
      free_count_r <= free_count_nxt;
      next_fresh_r <= next_fresh_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_index      = out_index_r;
  assign out_generation = out_generation_r;
  assign out_is_alive   = out_is_alive_r;
  assign out_status     = out_status_r;

  `GHA_ASSERT(a_free_le_fresh, free_count_r <= next_fresh_r, "free count above handed-out count")
  `GHA_ASSERT(a_fresh_bound, 32'(next_fresh_r) <= 32'(NUM_SLOTS), "fresh index past slot count")
  `GHA_ASSERT(a_full_state, (out_valid_r && out_status_r == ST_FULL) |-> (free_count_r == '0 && next_fresh_r == CW'(NUM_SLOTS)), "full reported with slots left")
  `GHA_ASSERT_NEXT(a_pop_count, s1_adv && s1_mode_r == MODE_SPAWN && free_count_r != '0, free_count_r == $past(free_count_r) - 1'b1, "pop did not lower free count")

endmodule
